// ----- hw/rtl/websocket_frame_deframer_unit_defines.svh -----
// Assertion macros used by the deframer queue.
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define WSFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsfd assertion failed");

// Antecedent implies consequent in the next cycle.
`define WSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsfd assertion failed");

`endif

// ----- hw/rtl/wsfd_pkg.sv -----
// Types and constants shared by the WebSocket deframer modules.
package wsfd_pkg;

    localparam int LENGTH_BITS_DEF = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [3:0] OPC_TEXT  = 4'h1;
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    typedef enum logic [2:0] {
        PH_HDR1 = 3'd0,
        PH_HDR2 = 3'd1,
        PH_EXT  = 3'd2,
        PH_MASK = 3'd3,
        PH_DATA = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_TEXT  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_UNSUP = 2'd2
    } t_kind;

    // One pending result: the back end applies the key byte to the data byte.
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key;
        logic       last;
        t_kind      kind;
        logic       fin;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ----- hw/rtl/wsfd_front.sv -----
// Header parser: tracks the frame phase and queues one command per result.
module wsfd_front import wsfd_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_phase                 r_phase, n_phase;
    logic [3:0]             r_opcode, n_opcode;
    logic                   r_fin, n_fin;
    logic                   r_masked, n_masked;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic [2:0]             r_cnt, n_cnt;
    logic [31:0]            r_key, n_key;
    logic [1:0]             r_pos, n_pos;

    logic [6:0]             len7;
    logic [LENGTH_BITS-1:0] ext_len;
    logic [LENGTH_BITS-1:0] done_len;
    logic                   done;
    logic [7:0]             key_byte;
    logic                   data_last;
    logic                   emit;
    t_cmd                   cmd;

    assign len7      = i_rx_byte[6:0];
    assign ext_len   = {r_len[LENGTH_BITS-9:0], i_rx_byte};
    assign key_byte  = r_key[{~r_pos, 3'b000} +: 8];
    assign data_last = (r_len == LENGTH_BITS'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR1;
            r_opcode <= '0;
            r_fin    <= 1'b0;
            r_masked <= 1'b0;
            r_len    <= '0;
            r_cnt    <= '0;
            r_key    <= '0;
            r_pos    <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_fin    <= n_fin;
            r_masked <= n_masked;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_key    <= n_key;
            r_pos    <= n_pos;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_fin    = r_fin;
        n_masked = r_masked;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_key    = r_key;
        n_pos    = r_pos;
        done     = 1'b0;
        done_len = r_len;
        emit     = 1'b0;
        cmd      = '{data: 8'd0, key: 8'd0, last: 1'b1, kind: KIND_UNSUP, fin: r_fin};

        case (r_phase)
            PH_HDR2: begin
                n_masked = i_rx_byte[7];
                n_key    = '0;
                n_pos    = '0;
                n_len    = '0;
                if (len7 == LEN_EXT16) begin
                    n_cnt   = 3'd1;
                    n_phase = PH_EXT;
                end else if (len7 == LEN_EXT64) begin
                    n_cnt   = 3'd7;
                    n_phase = PH_EXT;
                end else begin
                    n_len = LENGTH_BITS'(len7);
                    if (i_rx_byte[7]) begin
                        n_cnt   = 3'd3;
                        n_phase = PH_MASK;
                    end else begin
                        done     = 1'b1;
                        done_len = LENGTH_BITS'(len7);
                    end
                end
            end
            PH_EXT: begin
                n_len = ext_len;
                if (r_cnt != 3'd0) begin
                    n_cnt = r_cnt - 3'd1;
                end else if (r_masked) begin
                    n_cnt   = 3'd3;
                    n_phase = PH_MASK;
                end else begin
                    done     = 1'b1;
                    done_len = ext_len;
                end
            end
            PH_MASK: begin
                n_key = {r_key[23:0], i_rx_byte};
                if (r_cnt != 3'd0) begin
                    n_cnt = r_cnt - 3'd1;
                end else begin
                    done = 1'b1;
                end
            end
            PH_DATA: begin
                n_pos = r_pos + 2'd1;
                n_len = r_len - LENGTH_BITS'(1);
                if (data_last) begin
                    n_phase = PH_HDR1;
                end
                if (r_opcode == OPC_TEXT) begin
                    emit     = 1'b1;
                    cmd.data = i_rx_byte;
                    cmd.key  = key_byte;
                    cmd.last = data_last;
                    cmd.kind = KIND_TEXT;
                end else begin
                    emit = data_last;
                end
            end
            default: begin
                n_fin    = i_rx_byte[7];
                n_opcode = i_rx_byte[3:0];
                n_cnt    = '0;
                n_phase  = PH_HDR2;
            end
        endcase

        // Header complete: an empty frame ends here with its single result; otherwise the payload follows.
        if (done) begin
            if (done_len == '0) begin
                n_phase  = PH_HDR1;
                emit     = 1'b1;
                cmd.kind = (r_opcode == OPC_TEXT) ? KIND_EMPTY : KIND_UNSUP;
            end else begin
                n_phase = PH_DATA;
            end
        end
    end

    assign o_push = i_accept && emit;
    assign o_cmd  = cmd;

endmodule

// ----- hw/rtl/wsfd_queue.sv -----
// Short command queue between the parser and the output stage.
`include "websocket_frame_deframer_unit_defines.svh"

module wsfd_queue import wsfd_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cmd   i_cmd,
    input  logic   i_pop,
    output t_cmd   o_cmd,
    output t_qstat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             full;
    logic             empty;
    logic             push;
    logic             pop;

    assign full  = (r_cnt == CNT_W'(DEPTH));
    assign empty = (r_cnt == '0);
    assign push  = i_push && !full;
    assign pop   = i_pop && !empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_cmd        = r_mem[r_rd];
    assign o_stat.full  = full;
    assign o_stat.empty = empty;

    `WSFD_ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(DEPTH))
    `WSFD_ASSERT_NEXT(a_cnt_grow, i_clk, i_rst_n, push && !pop, r_cnt == $past(r_cnt) + 1'b1)
    `WSFD_ASSERT_NEXT(a_empty_hold, i_clk, i_rst_n, empty && !i_push, r_cnt == '0)
    `WSFD_ASSERT_IMPL(a_ptr_track, i_clk, i_rst_n, empty || full, r_wr == r_rd)

endmodule

// ----- hw/rtl/wsfd_back.sv -----
// Output stage: unmasks the queued byte and holds the result beat.
module wsfd_back import wsfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  t_qstat     i_stat,
    output logic       o_pop,
    input  logic       i_ready,
    output logic       o_valid,
    output logic [7:0] o_payload_byte,
    output logic       o_last_byte,
    output logic [1:0] o_kind,
    output logic       o_fin_flag
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    t_kind      r_kind;
    logic       r_fin;
    logic       load;

    // Advance when the queue holds a command and the output register is free or being drained.
    assign load = !i_stat.empty && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_cmd.data ^ i_cmd.key;
            r_last <= i_cmd.last;
            r_kind <= i_cmd.kind;
            r_fin  <= i_cmd.fin;
        end
    end

    assign o_pop          = load;
    assign o_valid        = r_valid;
    assign o_payload_byte = r_byte;
    assign o_last_byte    = r_last;
    assign o_kind         = r_kind;
    assign o_fin_flag     = r_fin;

endmodule

// ----- hw/rtl/websocket_frame_deframer_unit.sv -----
// A byte that produces a result is written into the queue when accepted, then loaded into the
// output register, which holds it on the outputs until it is taken.
// Throughput: one byte per cycle while the queue is not full, set by the header parser and
// its payload length down-counter; a QUEUE_DEPTH-entry queue absorbs output stalls.
// Reset (synchronous, active low) returns the parser to the first header byte,
// empties the queue and drops any pending output beat.
module websocket_frame_deframer_unit import wsfd_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_payload_byte,
    output logic       o_last_byte,
    output logic [1:0] o_kind,
    output logic       o_fin_flag
);

    logic   accept;
    logic   push;
    logic   pop;
    t_cmd   push_cmd;
    t_cmd   head_cmd;
    t_qstat qstat;

    assign o_in_ready = !qstat.full;
    assign accept     = i_in_valid && !qstat.full;

    wsfd_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    wsfd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (qstat)
    );

    wsfd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (head_cmd),
        .i_stat         (qstat),
        .o_pop          (pop),
        .i_ready        (i_out_ready),
        .o_valid        (o_out_valid),
        .o_payload_byte (o_payload_byte),
        .o_last_byte    (o_last_byte),
        .o_kind         (o_kind),
        .o_fin_flag     (o_fin_flag)
    );

endmodule
